// ===== sv/b2b_pkg.sv =====
// b2b_pkg: types, constants and helper functions for the blake2b hash block
// no dependencies
package b2b_pkg;

    localparam int unsigned RoundCount = 12;
    localparam int unsigned BlockBytes = 128;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [3:0]  valid_bytes;
        logic        last_digest_word;
    } out_item_t;

    typedef enum logic [1:0] {
        REG_DIGEST_LENGTH = 2'd0,
        REG_KEY_LENGTH    = 2'd1,
        REG_LAST_NODE     = 2'd2
    } reg_index_t;

    function automatic logic [63:0] iv_word(input logic [2:0] i);
        logic [63:0] r;
        case (i)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            default: r = 64'h5be0cd19137e2179;
        endcase
        return r;
    endfunction

    // message word index for round r (0..9), slot s (0..15)
    function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] s);
        logic [63:0] row;
        case (r)
            4'd0: row = 64'hfedcba9876543210;
            4'd1: row = 64'h357b20c16df984ae;
            4'd2: row = 64'h491763eadf250c8b;
            4'd3: row = 64'h8f04a562ebcd1397;
            4'd4: row = 64'hd386cb1efa427509;
            4'd5: row = 64'h91ef57d438b0a6c2;
            4'd6: row = 64'hb8293670a4def15c;
            4'd7: row = 64'ha2684f05931ce7bd;
            4'd8: row = 64'h5a417d2c803b9ef6;
            default: row = 64'h0dc3e9bf5167482a;
        endcase
        return row[{s, 2'b00} +: 4];
    endfunction

    // v indices a,b,c,d for G step g (0..7)
    function automatic logic [15:0] g_idx(input logic [2:0] g);
        logic [15:0] r;
        case (g)
            3'd0: r = 16'hc840;
            3'd1: r = 16'hd951;
            3'd2: r = 16'hea62;
            3'd3: r = 16'hfb73;
            3'd4: r = 16'hfa50;
            3'd5: r = 16'hcb61;
            3'd6: r = 16'hd872;
            default: r = 16'he943;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] eff_digest(input logic [6:0] dl);
        logic [6:0] r;
        if (dl == 7'd0) begin
            r = 7'd1;
        end else if (dl > 7'd64) begin
            r = 7'd64;
        end else begin
            r = dl;
        end
        return r;
    endfunction

    function automatic logic [63:0] param_word(input logic [6:0] dl, input logic [6:0] kl);
        logic [6:0] k;
        k = (kl > 7'd64) ? 7'd64 : kl;
        return {32'd0, 8'd1, 8'd1, 1'b0, k, 1'b0, eff_digest(dl)};
    endfunction

endpackage

// ===== sv/blake2b_hash_top.sv =====
// blake2b_hash_top: streaming BLAKE2b engine with block buffer memory
// depends on b2b_pkg and b2b_round
// Words are accepted only while the engine is idle and no register write is
// pending; the bytes of a word are then appended to the 16x64 block memory one
// per cycle, pausing while a block compression runs. When a byte arrives at a
// full buffer, a block compression runs (setup, 12 rounds of 16 half-G steps on
// the shared mix unit at one step per cycle, chain update) before it is stored.
// A final word is followed by zero padding of the rest of the block and the
// final compression; then ceil(L/8) digest words leave, where L is the digest
// length clamped to 1..64, and the input stays blocked until the last one is
// accepted. Register writes are taken only while idle. The message memory read
// is registered.
module blake2b_hash_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  b2b_pkg::in_item_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output b2b_pkg::out_item_t    m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [63:0]           cfg_data
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_SHIFT, ST_LOAD, ST_RUN, ST_FIN, ST_OUT
    } state_t;

    state_t      state_reg;
    logic [63:0] msg_mem [16];
    logic [63:0] rd_reg;
    logic [3:0]  rd_addr;
    logic [63:0] h_reg [8];
    logic [63:0] acc_reg;
    logic [7:0]  fill_reg;
    logic [127:0] cnt_reg;
    logic [6:0]  dl_reg, kl_reg;
    logic        ln_reg;
    logic        final_reg;
    logic        last_pend_reg;
    logic [3:0]  pend_n_reg;
    logic [63:0] pend_w_reg;
    logic [4:0]  wr_ptr_reg;
    logic [2:0]  out_k_reg;
    logic [6:0]  rem_reg;
    logic [63:0] init_v [16];
    logic [63:0] v_out [16];
    logic [3:0]  msg_sel;
    logic        rstart, rdone;
    logic [3:0]  cnt_in;
    logic [127:0] cnt_fin;

    assign cnt_in = (s_data.byte_count > 4'd8) ? 4'd8 : s_data.byte_count;
    assign s_ready = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign rstart = (state_reg == ST_LOAD);
    assign cnt_fin = cnt_reg + {120'd0, fill_reg};

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            init_v[i] = h_reg[i];
            init_v[i + 8] = b2b_pkg::iv_word(3'(i));
        end
        init_v[12] = init_v[12] ^ (final_reg ? cnt_fin[63:0] : cnt_reg[63:0]);
        init_v[13] = init_v[13] ^ (final_reg ? cnt_fin[127:64] : cnt_reg[127:64]);
        if (final_reg) begin
            init_v[14] = ~init_v[14];
            if (ln_reg) begin
                init_v[15] = ~init_v[15];
            end
        end
    end

    b2b_round u_round (
        .aclk(aclk), .aresetn(aresetn), .start(rstart), .init_v(init_v),
        .msg_x(rd_reg), .msg_sel(msg_sel), .done(rdone), .v_out(v_out)
    );

    // read port: fetched in the cycle before the mix step that uses it
    assign rd_addr = msg_sel;

    always_ff @(posedge aclk) begin
        rd_reg <= msg_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dl_reg <= 7'd64;
            kl_reg <= 7'd0;
            ln_reg <= 1'b0;
            fill_reg <= '0;
            cnt_reg <= '0;
            final_reg <= 1'b0;
            last_pend_reg <= 1'b0;
            m_valid <= 1'b0;
            acc_reg <= '0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= b2b_pkg::iv_word(3'(i)) ^
                    (i == 0 ? b2b_pkg::param_word(7'd64, 7'd0) : 64'd0);
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid) begin
                        logic [6:0] ndl, nkl;
                        ndl = dl_reg;
                        nkl = kl_reg;
                        case (cfg_index)
                            b2b_pkg::REG_DIGEST_LENGTH: ndl = cfg_data[6:0];
                            b2b_pkg::REG_KEY_LENGTH:    nkl = cfg_data[6:0];
                            b2b_pkg::REG_LAST_NODE:     ln_reg <= cfg_data[0];
                            default: ;
                        endcase
                        dl_reg <= ndl;
                        kl_reg <= nkl;
                        if (cfg_index <= b2b_pkg::REG_LAST_NODE && fill_reg == 8'd0 &&
                            cnt_reg == '0) begin
                            h_reg[0] <= b2b_pkg::iv_word(3'd0) ^ b2b_pkg::param_word(ndl, nkl);
                        end
                    end else if (s_valid) begin
                        pend_w_reg <= s_data.data_word;
                        pend_n_reg <= cnt_in;
                        last_pend_reg <= s_data.last_word;
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    if (pend_n_reg != 4'd0 && fill_reg == 8'd128) begin
                        cnt_reg <= cnt_reg + 128'd128;
                        final_reg <= 1'b0;
                        fill_reg <= '0;
                        acc_reg <= '0;
                        state_reg <= ST_LOAD;
                    end else if (pend_n_reg != 4'd0) begin
                        // append one byte
                        logic [63:0] a;
                        a = acc_reg;
                        a[{fill_reg[2:0], 3'b000} +: 8] = pend_w_reg[7:0];
                        acc_reg <= (fill_reg[2:0] == 3'd7) ? 64'd0 : a;
                        msg_mem[fill_reg[6:3]] <= a;
                        pend_w_reg <= pend_w_reg >> 8;
                        pend_n_reg <= pend_n_reg - 4'd1;
                        fill_reg <= fill_reg + 8'd1;
                    end else if (last_pend_reg) begin
                        // first word to clear, 16 when the buffer is full
                        if (fill_reg[7]) begin
                            wr_ptr_reg <= 5'd16;
                        end else begin
                            wr_ptr_reg <= {1'b0, fill_reg[6:3]} +
                                ((fill_reg[2:0] != 3'd0) ? 5'd1 : 5'd0);
                        end
                        state_reg <= ST_FIN;
                        final_reg <= 1'b1;
                        acc_reg <= '0;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FIN: begin
                    // zero pad remaining words
                    if (!wr_ptr_reg[4]) begin
                        msg_mem[wr_ptr_reg[3:0]] <= '0;
                        wr_ptr_reg <= wr_ptr_reg + 5'd1;
                    end else begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    if (rdone) begin
                        for (int i = 0; i < 8; i++) begin
                            h_reg[i] <= h_reg[i] ^ v_out[i] ^ v_out[i + 8];
                        end
                        if (final_reg) begin
                            out_k_reg <= '0;
                            rem_reg <= b2b_pkg::eff_digest(dl_reg);
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_SHIFT;
                        end
                    end
                end
                ST_OUT: begin
                    if (!m_valid) begin
                        m_data.digest_word <= h_reg[out_k_reg];
                        m_data.valid_bytes <= (rem_reg > 7'd8) ? 4'd8 : rem_reg[3:0];
                        m_data.last_digest_word <= (rem_reg <= 7'd8);
                        m_valid <= 1'b1;
                    end else if (m_ready) begin
                        m_valid <= 1'b0;
                        out_k_reg <= out_k_reg + 3'd1;
                        rem_reg <= (rem_reg > 7'd8) ? rem_reg - 7'd8 : 7'd0;
                        if (rem_reg <= 7'd8) begin
                            fill_reg <= '0;
                            cnt_reg <= '0;
                            final_reg <= 1'b0;
                            last_pend_reg <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                h_reg[i] <= b2b_pkg::iv_word(3'(i)) ^
                                    (i == 0 ? b2b_pkg::param_word(dl_reg, kl_reg) : 64'd0);
                            end
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/b2b_round.sv =====
// b2b_round: one half of a G mix per cycle over a 16-word working vector
// depends on b2b_pkg
module b2b_round (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] init_v [16],
    input  logic [63:0] msg_x,
    output logic [3:0]  msg_sel,
    output logic        done,
    output logic [63:0] v_out [16]
);
    logic [63:0] v_reg [16];
    logic [3:0]  rnd_reg;
    logic [2:0]  g_reg;
    logic        half_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  nrnd;
    logic [3:0]  nrmod;
    logic [2:0]  ng;
    logic        nhalf;
    logic [15:0] idx;
    logic [63:0] a_n, b_n, c_n, d_n, t;

    // next step, whose message word is fetched in the cycle before it runs
    always_comb begin
        if (start) begin
            nrnd  = '0;
            ng    = '0;
            nhalf = 1'b0;
        end else begin
            nhalf = ~half_reg;
            ng    = half_reg ? g_reg + 3'd1 : g_reg;
            nrnd  = (half_reg && g_reg == 3'd7) ? rnd_reg + 4'd1 : rnd_reg;
        end
    end

    assign nrmod = (nrnd >= 4'd10) ? nrnd - 4'd10 : nrnd;
    assign idx = b2b_pkg::g_idx(g_reg);
    assign msg_sel = b2b_pkg::sigma(nrmod, {ng, nhalf});

    always_comb begin
        a_n = v_reg[idx[3:0]] + v_reg[idx[7:4]] + msg_x;
        t = v_reg[idx[15:12]] ^ a_n;
        if (!half_reg) begin
            d_n = {t[31:0], t[63:32]};
        end else begin
            d_n = {t[15:0], t[63:16]};
        end
        c_n = v_reg[idx[11:8]] + d_n;
        t = v_reg[idx[7:4]] ^ c_n;
        if (!half_reg) begin
            b_n = {t[23:0], t[63:24]};
        end else begin
            b_n = {t[62:0], t[63]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
            g_reg    <= '0;
            half_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                v_reg    <= init_v;
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
                g_reg    <= '0;
                half_reg <= 1'b0;
            end else if (busy_reg) begin
                v_reg[idx[3:0]]   <= a_n;
                v_reg[idx[7:4]]   <= b_n;
                v_reg[idx[11:8]]  <= c_n;
                v_reg[idx[15:12]] <= d_n;
                half_reg <= ~half_reg;
                if (half_reg) begin
                    g_reg <= g_reg + 3'd1;
                    if (g_reg == 3'd7) begin
                        if (rnd_reg == 4'(b2b_pkg::RoundCount - 1)) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end else begin
                            rnd_reg <= rnd_reg + 4'd1;
                        end
                    end
                end
            end
        end
    end

    assign done = done_reg;
    assign v_out = v_reg;
endmodule

// ===== sv/b2b_check.sv =====
// b2b_check: port-level assertions for blake2b_hash_top
// depends on b2b_pkg; bound to blake2b_hash_top
module b2b_check (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               cfg_ready,
    input b2b_pkg::out_item_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while emitting");
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> cfg_ready) else $error("config port closed while idle");
    a_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.valid_bytes != 4'd0 && m_data.valid_bytes <= 4'd8)
        else $error("bad valid_bytes");
endmodule

bind blake2b_hash_top b2b_check u_check (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready), .m_valid(m_valid),
    .m_ready(m_ready), .cfg_ready(cfg_ready), .m_data(m_data)
);
